>>> hw/rtl/triangle_max_path_sum_assert.svh
// ----------------------------------------------------------------------------
// triangle_max_path_sum assertion macros
// shared property wrappers for the checker of the triangle path-sum block
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MAX_PATH_SUM_ASSERT_SVH
`define TRIANGLE_MAX_PATH_SUM_ASSERT_SVH

// property checked while reset is released
`define TMPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define TMPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg
// widths, register map and shared types of the triangle path-sum block
// ----------------------------------------------------------------------------
package tmps_pkg;

    // triangle size and derived widths
    localparam int MAX_ROWS = 128;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W    = ROW_W + 1;
    localparam int CFG_W    = 8;
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // data widths
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 23;
    localparam int TDATA_S_W = 16;
    localparam int TDATA_M_W = 24;

    localparam logic signed [SUM_W-1:0] SUM_MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ROW_COUNT = 1'b0;

    // write side of the partial-sum row memory
    typedef struct packed {
        logic                    en;
        logic [ROW_W-1:0]        addr;
        logic signed [SUM_W-1:0] data;
    } row_wr_t;

endpackage

>>> hw/rtl/tmps_row_ram.sv
// ----------------------------------------------------------------------------
// tmps_row_ram
// row of partial sums: one write and one registered read port per cycle,
// with forwarding of a write that lands on the entry being read
// ----------------------------------------------------------------------------
module tmps_row_ram
    import tmps_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  row_wr_t                 wr,
    input  logic                    rd_en,
    input  logic [ROW_W-1:0]        rd_addr,
    output logic signed [SUM_W-1:0] rd_data
);

    logic signed [SUM_W-1:0] mem [MAX_ROWS];
    logic signed [SUM_W-1:0] rd_data_reg;
    logic signed [SUM_W-1:0] fwd_data_reg;
    logic                    fwd_reg;

    // storage: write and read-old-value read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    // forwarding flag for a same-edge write to the read entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

>>> hw/rtl/triangle_max_path_sum.sv
// ----------------------------------------------------------------------------
// triangle_max_path_sum
// largest apex-to-base path sum of a number triangle streamed in row-major
// order, using one row of partial sums kept in a dual-port memory
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_       | in        | tdata[15:0] entry_value
//  m_       | out       | tdata[22:0] max_sum, one transaction per triangle
//  apb      | in/out    | register 0: row_count[7:0]
//
// one entry per cycle unless stalled; a final entry goes through stage 1, then the output register
// stage 0 reads the parent column from the row memory, stage 1 adds, writes back
// and updates the running maximum; the left parent comes from the previous read
// aresetn is synchronous; no memory clearing pass is needed after reset
// input stalls only when a final sum meets a result still waiting on m_
// ----------------------------------------------------------------------------
module triangle_max_path_sum
    import tmps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_S_W-1:0]  s_tdata,   // [15:0] entry_value
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_M_W-1:0]  m_tdata,   // [22:0] max_sum, [23] zero
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    // configuration and position state
    logic [CFG_W-1:0]        row_count_reg;
    logic [ROW_W-1:0]        row_pos_reg;
    logic [ROW_W-1:0]        col_pos_reg;
    logic signed [SUM_W-1:0] best_reg;
    logic signed [SUM_W-1:0] left_reg;

    // stage 1
    logic                    s1_valid_reg;
    logic signed [VAL_W-1:0] s1_value_reg;
    logic [ROW_W-1:0]        s1_col_reg;
    logic                    s1_have_left_reg;
    logic                    s1_have_above_reg;
    logic                    s1_last_row_reg;
    logic                    s1_final_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_data_reg;

    logic                    cfg_wr;
    logic [CMP_W-1:0]        rows_cmp;
    logic [CNT_W-1:0]        rows_eff;
    logic                    last_row;
    logic                    row_end;
    logic                    accept;
    logic                    s1_go;
    logic signed [SUM_W-1:0] above;
    logic signed [SUM_W-1:0] parent;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] best_next;
    row_wr_t                 row_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_ROW_COUNT);
    assign prdata = (paddr[APB_AW-1] == REG_ROW_COUNT) ? APB_DW'(row_count_reg) : '0;

    // effective row count: zero means one, clipped to the row memory depth
    always_comb begin
        rows_cmp = CMP_W'(row_count_reg);
        if (rows_cmp == '0) begin
            rows_cmp = CMP_W'(1);
        end else if (rows_cmp > CMP_W'(MAX_ROWS)) begin
            rows_cmp = CMP_W'(MAX_ROWS);
        end
        rows_eff = rows_cmp[CNT_W-1:0];
    end

    // stage 0 position decode
    assign last_row = ((CNT_W'(row_pos_reg) + CNT_W'(1)) == rows_eff);
    assign row_end  = (col_pos_reg == row_pos_reg);

    // handshake
    assign s1_go    = s1_valid_reg && (!s1_final_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    // stage 1 sum
    always_comb begin
        if (s1_have_left_reg && s1_have_above_reg) begin
            parent = (left_reg > above) ? left_reg : above;
        end else if (s1_have_left_reg) begin
            parent = left_reg;
        end else if (s1_have_above_reg) begin
            parent = above;
        end else begin
            parent = '0;
        end
        sum = SUM_W'(s1_value_reg) + parent;
        best_next = (s1_last_row_reg && (sum > best_reg)) ? sum : best_reg;
    end

    assign row_wr.en   = s1_go;
    assign row_wr.addr = s1_col_reg;
    assign row_wr.data = sum;

    tmps_row_ram u_row_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (row_wr),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (above)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= CFG_W'(1);
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            best_reg      <= SUM_MOST_NEG;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // position walk
            if (cfg_wr) begin
                row_count_reg <= pwdata[CFG_W-1:0];
                row_pos_reg   <= '0;
                col_pos_reg   <= '0;
            end else if (accept) begin
                if (row_end) begin
                    col_pos_reg <= '0;
                    row_pos_reg <= last_row ? '0 : row_pos_reg + ROW_W'(1);
                end else begin
                    col_pos_reg <= col_pos_reg + ROW_W'(1);
                end
            end

            // running maximum of the last row
            if (cfg_wr) begin
                best_reg <= SUM_MOST_NEG;
            end else if (s1_go) begin
                best_reg <= s1_final_reg ? SUM_MOST_NEG : best_next;
            end

            // stage 1 occupancy
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end

            // result register
            if (s1_go && s1_final_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg      <= s_tdata[VAL_W-1:0];
            s1_col_reg        <= col_pos_reg;
            s1_have_left_reg  <= (row_pos_reg != '0) && (col_pos_reg != '0);
            s1_have_above_reg <= (row_pos_reg != '0) && !row_end;
            s1_last_row_reg   <= last_row;
            s1_final_reg      <= last_row && row_end;
        end
        if (s1_go) begin
            left_reg <= above;
        end
        if (s1_go && s1_final_reg) begin
            out_data_reg <= best_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_M_W'($unsigned(out_data_reg));

endmodule

>>> hw/rtl/tmps_checker.sv
// ----------------------------------------------------------------------------
// tmps_checker
// port-level checks of the triangle path-sum block, bound to the top level
// ----------------------------------------------------------------------------
`include "triangle_max_path_sum_assert.svh"

module tmps_checker
    import tmps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TDATA_M_W-1:0] m_tdata,
    input logic                 pready
);

    // a waiting result holds until taken
    `TMPS_ASSERT(a_result_held, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")

    // a new result follows an accepted input transaction
    `TMPS_ASSERT(a_result_latency, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without matching input")

    // padding bit of the result stays clear
    `TMPS_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> (m_tdata[TDATA_M_W-1] == 1'b0), "result padding set")

    // reset empties the result register
    `TMPS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // configuration port never waits
    `TMPS_ASSERT(a_pready_high, aclk, aresetn, pready, "pready dropped")

endmodule

bind triangle_max_path_sum tmps_checker u_tmps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

>>> tb/tb_triangle_max_path_sum.sv
// ----------------------------------------------------------------------------
// tb_triangle_max_path_sum
// streams number triangles into the block, row-major, under random valid and
// ready gaps, and checks every max_sum transaction against a top-down
// partial-sum predictor; row_count is reprogrammed between triangles and in
// the middle of one, and a long load through a row_count above the maximum
// runs on extreme entries before it is abandoned
// ----------------------------------------------------------------------------
module tb_triangle_max_path_sum
    import tmps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_AW-1:0] ADDR_ROW_COUNT = APB_AW'(4 * int'(REG_ROW_COUNT));
    localparam int RANDOM_ENTRIES = 1450;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic {DO_WRITE, DO_ENTRY} step_kind_e;

    typedef struct {
        step_kind_e kind;
        int         val;     // row_count for a write, entry_value otherwise
        bit         fixed;   // result known at a glance
        int         want;
    } step_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_S_W-1:0] s_tdata  = '0;   // [15:0] entry_value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_M_W-1:0] m_tdata;         // [22:0] max_sum, [23] zero
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor state: one row of partial sums plus load position
    int         col_sum [MAX_ROWS];
    int         row_at;
    int         col_at;
    int         best_base;
    int         left_sum;
    logic [7:0] rows_reg;

    logic signed [SUM_W-1:0] max_sum_due [$];
    int mismatch_count = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    triangle_max_path_sum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int gap_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [15:0] pick_entry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h7fff;
        if (r < 20) return 16'h8000;
        if (r < 25) return 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic restart_load();
        row_at    = 0;
        col_at    = 0;
        best_base = -4194304;
        left_sum  = 0;
    endtask

    // top-down step: entry plus the better usable parent
    task automatic fold_entry(input logic signed [15:0] v, output bit done,
                              output logic signed [SUM_W-1:0] total);
        int  rows;
        int  above;
        int  s;
        bit  has_left;
        bit  has_above;
        rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
        done  = 1'b0;
        total = '0;
        above = col_sum[col_at];
        has_left  = (row_at > 0) && (col_at > 0);
        has_above = (row_at > 0) && (col_at < row_at);
        if (has_left && has_above)
            s = int'(v) + ((left_sum > above) ? left_sum : above);
        else if (has_left)
            s = int'(v) + left_sum;
        else if (has_above)
            s = int'(v) + above;
        else
            s = int'(v);
        left_sum = above;
        col_sum[col_at] = s;
        if (row_at + 1 == rows && s > best_base) best_base = s;
        if (col_at < row_at) begin
            col_at++;
        end else if (row_at + 1 < rows) begin
            row_at++;
            col_at   = 0;
            left_sum = 0;
        end else begin
            done  = 1'b1;
            total = SUM_W'(best_base);
            restart_load();
        end
    endtask

    // one input transaction, predicted at the accepting edge
    task automatic send_entry(input logic [15:0] v, input bit fixed, input int want);
        int                      gap;
        bit                      done;
        logic signed [SUM_W-1:0] total;
        gap = gap_len(tx_steady);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        fold_entry(v, done, total);
        if (done) max_sum_due.push_back(fixed ? SUM_W'(want) : total);
    endtask

    // drop valid and let the pipeline drain before touching the register
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (max_sum_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write row_count, then read it back
    task automatic write_rows(input logic [7:0] n);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ROW_COUNT;
        pwdata  <= APB_DW'(n);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rows_reg = n;
        restart_load();
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DW'(n)) begin
            $error("row_count: expected %0d, actual %0d", n, prdata);
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random ready pattern
    initial begin
        int stall;
        @(negedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            stall = gap_len(rx_steady);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        logic signed [SUM_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (max_sum_due.size() == 0) begin
                $error("max_sum: expected none, actual %0d", $signed(m_tdata[SUM_W-1:0]));
                mismatch_count++;
            end else begin
                want = max_sum_due.pop_front();
                if (m_tdata[SUM_W-1:0] !== want) begin
                    $error("max_sum: expected %0d, actual %0d", want,
                           $signed(m_tdata[SUM_W-1:0]));
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        step_t plan [18 + 6];
        int    rand_entries;
        int    n;
        int    eff;
        int    size;
        int    r;
        int    cut;

        plan = '{
            // power-up row_count is one: every entry is a whole triangle
            '{DO_ENTRY, 0,      1'b1, 0},
            '{DO_ENTRY, 32767,  1'b1, 32767},
            '{DO_ENTRY, -32768, 1'b1, -32768},
            // zero rows acts as one row
            '{DO_WRITE, 0,      1'b0, 0},
            '{DO_ENTRY, -1,     1'b1, -1},
            '{DO_WRITE, 2,      1'b0, 0},
            '{DO_ENTRY, 5,      1'b0, 0},
            '{DO_ENTRY, 3,      1'b0, 0},
            '{DO_ENTRY, -7,     1'b1, 8},
            '{DO_WRITE, 3,      1'b0, 0},
            '{DO_ENTRY, 1,      1'b0, 0},
            '{DO_ENTRY, -2,     1'b0, 0},
            '{DO_ENTRY, 3,      1'b0, 0},
            '{DO_ENTRY, 4,      1'b0, 0},
            '{DO_ENTRY, -32768, 1'b0, 0},
            '{DO_ENTRY, 6,      1'b0, 0},
            // a load cut short by a register write starts over at the apex
            '{DO_WRITE, 3,      1'b0, 0},
            '{DO_ENTRY, 9,      1'b0, 0},
            '{DO_ENTRY, 9,      1'b0, 0},
            '{DO_WRITE, 2,      1'b0, 0},
            '{DO_ENTRY, 1,      1'b0, 0},
            '{DO_ENTRY, 2,      1'b0, 0},
            '{DO_ENTRY, 3,      1'b0, 0},
            '{DO_WRITE, 1,      1'b0, 0}
        };

        for (int i = 0; i < MAX_ROWS; i++) col_sum[i] = 0;
        rows_reg = 8'd1;
        restart_load();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].kind == DO_WRITE) begin
                settle();
                write_rows(8'(plan[i].val));
            end else begin
                send_entry(16'(plan[i].val), plan[i].fixed, plan[i].want);
            end
        end

        // row_count above the maximum: a long load of extreme entries
        // that must not finish early, then abandoned
        settle();
        write_rows(8'd255);
        repeat (MAX_ROWS) send_entry(16'h7fff, 1'b0, 0);
        repeat (MAX_ROWS) send_entry(16'h8000, 1'b0, 0);

        // random triangles, mostly small, some loads abandoned midway
        rand_entries = 0;
        while (rand_entries < RANDOM_ENTRIES) begin
            r = $urandom_range(0, 99);
            if (r < 8)       n = 0;
            else if (r < 70) n = $urandom_range(1, 6);
            else if (r < 95) n = $urandom_range(7, 16);
            else             n = $urandom_range(17, 30);
            settle();
            write_rows(8'(n));
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            eff  = (n == 0) ? 1 : n;
            size = eff * (eff + 1) / 2;
            repeat ($urandom_range(1, 5)) begin
                repeat (size) send_entry(pick_entry(), 1'b0, 0);
                rand_entries += size;
            end
            if (eff > 1 && $urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, size - 1);
                repeat (cut) send_entry(pick_entry(), 1'b0, 0);
                rand_entries += cut;
            end
        end

        // drain and report
        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tmps_pkg.sv
hw/rtl/tmps_row_ram.sv
hw/rtl/triangle_max_path_sum.sv
hw/rtl/tmps_checker.sv
tb/tb_triangle_max_path_sum.sv
